// ===== sv/res_pkg.sv =====
// Shared types and constants for the ramped exponential smoother.
// Holds the microcode word layout, step codes and datapath status struct.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package res_pkg;

	// Field widths fixed by the filter definition.
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned DIV_W   = 31;
	localparam int unsigned STIFF_W = 5;
	localparam int unsigned ACC_W   = DATA_W + 2;

	localparam logic [STIFF_W-1:0] STIFF_MAX   = 5'd30;
	localparam logic [STIFF_W-1:0] STIFF_RESET = 5'd6;

	// Configuration port geometry.
	localparam int unsigned APB_AW = 3;
	localparam int unsigned APB_DW = 32;

	// The divider resolves two quotient bits per cycle.
	localparam int unsigned DIV_STEPS = DATA_W / 2;
	localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

	// Microprogram step addresses.
	localparam int unsigned STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_WAIT   = 4'd0;
	localparam logic [STEP_W-1:0] STEP_CMD    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_STIFF  = 4'd2;
	localparam logic [STEP_W-1:0] STEP_RAMP   = 4'd3;
	localparam logic [STEP_W-1:0] STEP_DIV_Y  = 4'd4;
	localparam logic [STEP_W-1:0] STEP_WAIT_Y = 4'd5;
	localparam logic [STEP_W-1:0] STEP_QUO1   = 4'd6;
	localparam logic [STEP_W-1:0] STEP_WAIT_A = 4'd7;
	localparam logic [STEP_W-1:0] STEP_OUT    = 4'd8;
	localparam logic [STEP_W-1:0] STEP_SUM    = 4'd9;
	localparam logic [STEP_W-1:0] STEP_CLEAR  = 4'd10;
	localparam logic [STEP_W-1:0] STEP_LAST   = STEP_CLEAR;

	// Datapath operation selected by a control word.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_LOAD,
		OP_STIFF,
		OP_RAMP,
		OP_DIV_Y,
		OP_QUO1,
		OP_SUM,
		OP_CLEAR
	} op_t;

	// Jump condition of a control word; C_NEXT never jumps.
	typedef enum logic [2:0] {
		C_NEXT,
		C_ALWAYS,
		C_NO_INPUT,
		C_CLEAR,
		C_STIFF_HIGH,
		C_DIV_BUSY,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t               op;
		cond_t             cond;
		logic [STEP_W-1:0] target;
	} uword_t;

	// Flags the datapath reports back to the sequencer.
	typedef struct packed {
		logic no_input;
		logic cmd_clear;
		logic stiff_high;
		logic div_busy;
		logic out_full;
	} status_t;

endpackage

// ===== sv/res_if.sv =====
// Valid/ready channel interfaces for the smoother's feed and result sides.
// Depends on res_pkg for the field widths.
`timescale 1ns / 1ps

interface res_in_if import res_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic                     command;
	logic signed [DATA_W-1:0] sample;

	modport source(output valid, command, sample, input ready);
	modport sink(input valid, command, sample, output ready);
endinterface

interface res_out_if import res_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] smoothed;

	modport source(output valid, smoothed, input ready);
	modport sink(input valid, smoothed, output ready);
endinterface

// ===== sv/res_rom.sv =====
// Microprogram ROM: one control word per step address.
// Depends on res_pkg for the control word layout and step codes.
`timescale 1ns / 1ps

module res_rom import res_pkg::*; (
	input  logic [STEP_W-1:0] step,
	output uword_t            uword
);

	// Wait, branch on the command, shrink the stiffness, ramp the divisor,
	// then two divisions, a final sum and the hand-off of the result.
	always_comb begin
		unique case (step)
			STEP_WAIT:   uword = '{op: OP_LOAD,  cond: C_NO_INPUT,   target: STEP_WAIT};
			STEP_CMD:    uword = '{op: OP_NOP,   cond: C_CLEAR,      target: STEP_CLEAR};
			STEP_STIFF:  uword = '{op: OP_STIFF, cond: C_STIFF_HIGH, target: STEP_STIFF};
			STEP_RAMP:   uword = '{op: OP_RAMP,  cond: C_NEXT,       target: STEP_WAIT};
			STEP_DIV_Y:  uword = '{op: OP_DIV_Y, cond: C_NEXT,       target: STEP_WAIT};
			STEP_WAIT_Y: uword = '{op: OP_NOP,   cond: C_DIV_BUSY,   target: STEP_WAIT_Y};
			STEP_QUO1:   uword = '{op: OP_QUO1,  cond: C_NEXT,       target: STEP_WAIT};
			STEP_WAIT_A: uword = '{op: OP_NOP,   cond: C_DIV_BUSY,   target: STEP_WAIT_A};
			STEP_OUT:    uword = '{op: OP_NOP,   cond: C_OUT_FULL,   target: STEP_OUT};
			STEP_SUM:    uword = '{op: OP_SUM,   cond: C_ALWAYS,     target: STEP_WAIT};
			STEP_CLEAR:  uword = '{op: OP_CLEAR, cond: C_ALWAYS,     target: STEP_WAIT};
			default:     uword = '{op: OP_NOP,   cond: C_ALWAYS,     target: STEP_WAIT};
		endcase
	end

endmodule

// ===== sv/res_div.sv =====
// Shared iterative unsigned divider, two quotient bits per cycle.
// Depends on res_pkg for widths and the iteration count.
`timescale 1ns / 1ps

module res_div import res_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DIV_W-1:0]  divisor,
	output logic              busy,
	output logic [DATA_W-1:0] quotient,
	output logic              rem_nz
);

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DATA_W-1:0]    num_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     den_q;

	logic [DATA_W-1:0] t1, t2;
	logic [DIV_W-1:0]  r1, r2;
	logic              ge1, ge2;

	// Two restoring steps; a partial remainder always stays below the divisor.
	always_comb begin
		t1  = {rem_q, num_q[DATA_W-1]};
		ge1 = t1 >= {1'b0, den_q};
		r1  = ge1 ? DIV_W'(t1 - {1'b0, den_q}) : t1[DIV_W-1:0];
		t2  = {r1, num_q[DATA_W-2]};
		ge2 = t2 >= {1'b0, den_q};
		r2  = ge2 ? DIV_W'(t2 - {1'b0, den_q}) : t2[DIV_W-1:0];
	end

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in below.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			num_q <= {num_q[DATA_W-3:0], ge1, ge2};
			rem_q <= r2;
		end
	end

	assign busy     = busy_q;
	assign quotient = num_q;
	assign rem_nz   = (rem_q != '0);

endmodule

// ===== sv/res_datapath.sv =====
// Filter datapath: state registers, stiffness and divisor logic, result register.
// Depends on res_pkg and instantiates the shared divider res_div.
`timescale 1ns / 1ps

module res_datapath import res_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  op_t                       op,
	input  logic [STIFF_W-1:0]        stiffness,
	input  logic                      in_valid,
	input  logic                      in_command,
	input  logic signed [DATA_W-1:0]  in_sample,
	input  logic                      out_ready,
	output logic                      out_valid,
	output logic signed [DATA_W-1:0]  out_smoothed,
	output status_t                   stat
);

	// Filter state.
	logic [DATA_W-1:0] y_q;
	logic [DATA_W-1:0] prev_q;
	logic [DIV_W-1:0]  div_q;

	// Per-transaction working registers.
	logic [DATA_W-1:0]  x_q;
	logic               cmd_q;
	logic [STIFF_W-1:0] s_q;
	logic [ACC_W-1:0]   acc_q;
	logic               avg_neg_q;
	logic               out_valid_q;
	logic [DATA_W-1:0]  out_data_q;

	logic               in_fire;
	logic               y_neg;
	logic [DATA_W-1:0]  y_mag;
	logic [DATA_W-1:0]  thr;
	logic               stiff_high;
	logic [DIV_W-1:0]   limit;
	logic [DIV_W-1:0]   div_n;
	logic [DATA_W:0]    hx, hp, x33, p33, avg, avg_abs;
	logic [ACC_W-1:0]   y34, q1_34, q1s, adj34, acc_n;
	logic [ACC_W-1:0]   q2_34, q2s, sum;
	logic [DATA_W-1:0]  sat;
	logic               div_start;
	logic [DATA_W-1:0]  div_dividend;
	logic               div_busy;
	logic [DATA_W-1:0]  div_quo;
	logic               div_rem_nz;

	assign in_fire = in_valid && (op == OP_LOAD);

	// Magnitude of the output and the stiffness reduction test.
	always_comb begin
		y_neg      = y_q[DATA_W-1];
		y_mag      = y_neg ? (~y_q + 1'b1) : y_q;
		thr        = {{(DATA_W-1){1'b0}}, 1'b1} << (5'd31 - s_q);
		stiff_high = (s_q != '0) && (y_mag >= thr);
	end

	// Divisor ramp toward two to the effective stiffness.
	always_comb begin
		limit = {{(DIV_W-1){1'b0}}, 1'b1} << s_q;
		priority if (div_q == '0) begin
			div_n = {{(DIV_W-1){1'b0}}, 1'b1};
		end else if (div_q < limit) begin
			div_n = div_q + 1'b1;
		end else begin
			div_n = limit;
		end
	end

	// Average of the sample and the previous sample, halves truncated toward zero.
	always_comb begin
		x33     = {x_q[DATA_W-1], x_q} + {{DATA_W{1'b0}}, x_q[DATA_W-1]};
		p33     = {prev_q[DATA_W-1], prev_q} + {{DATA_W{1'b0}}, prev_q[DATA_W-1]};
		hx      = {x33[DATA_W], x33[DATA_W:1]};
		hp      = {p33[DATA_W], p33[DATA_W:1]};
		avg     = hx + hp;
		avg_abs = avg[DATA_W] ? ((DATA_W+1)'(0) - avg) : avg;
	end

	// (d-1)*y/d equals y - y/d, corrected by one toward zero when y/d is inexact.
	always_comb begin
		y34   = {{2{y_q[DATA_W-1]}}, y_q};
		q1_34 = {2'b00, div_quo};
		q1s   = y_neg ? (ACC_W'(0) - q1_34) : q1_34;
		adj34 = div_rem_nz ? (y_neg ? {ACC_W{1'b1}} : ACC_W'(1)) : '0;
		acc_n = y34 - q1s - adj34;
	end

	// Final sum with saturation to the signed output range.
	always_comb begin
		q2_34 = {2'b00, div_quo};
		q2s   = avg_neg_q ? (ACC_W'(0) - q2_34) : q2_34;
		sum   = acc_q + q2s;
		if ((sum[ACC_W-1:DATA_W-1] == '0) || (sum[ACC_W-1:DATA_W-1] == '1)) begin
			sat = sum[DATA_W-1:0];
		end else if (sum[ACC_W-1]) begin
			sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sat = {1'b0, {(DATA_W-1){1'b1}}};
		end
	end

	// The divider takes |y| first and |average| second.
	assign div_start    = (op == OP_DIV_Y) || (op == OP_QUO1);
	assign div_dividend = (op == OP_DIV_Y) ? y_mag : avg_abs[DATA_W-1:0];

	res_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_q),
		.busy     (div_busy),
		.quotient (div_quo),
		.rem_nz   (div_rem_nz)
	);

	// Filter state updates.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q    <= '0;
			prev_q <= '0;
			div_q  <= '0;
		end else begin
			unique case (op)
				OP_CLEAR: begin
					y_q    <= '0;
					prev_q <= '0;
					div_q  <= '0;
				end
				OP_RAMP: begin
					div_q <= div_n;
				end
				OP_SUM: begin
					y_q    <= sat;
					prev_q <= x_q;
				end
				default: begin
				end
			endcase
		end
	end

	// Working registers of the current transaction.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q   <= in_sample;
			cmd_q <= in_command;
			s_q   <= (stiffness > STIFF_MAX) ? STIFF_MAX : stiffness;
		end
		if (op == OP_STIFF && stiff_high) begin
			s_q <= s_q - 1'b1;
		end
		if (op == OP_QUO1) begin
			acc_q     <= acc_n;
			avg_neg_q <= avg[DATA_W];
		end
		if (op == OP_SUM) begin
			out_data_q <= sat;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == OP_SUM) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_smoothed = out_data_q;

	always_comb begin
		stat.no_input   = !in_valid;
		stat.cmd_clear  = cmd_q;
		stat.stiff_high = stiff_high;
		stat.div_busy   = div_busy;
		stat.out_full   = out_valid_q && !out_ready;
	end

	// The ramp never takes the divisor above two to the thirtieth.
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		div_q <= {1'b1, {(DIV_W-1){1'b0}}})
		else $error("divisor above its largest value");

	// A clear leaves output, previous sample and divisor at zero.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		op == OP_CLEAR |=> (y_q == '0) && (prev_q == '0) && (div_q == '0))
		else $error("filter state not cleared");

endmodule

// ===== sv/ramped_exponential_smoother.sv =====
// Sequencing: a feed runs the stiffness reduction loop (0 to 30 reductions, one per
// cycle), two passes through the shared radix-4 divider and the final sum before its
// result is handed off; a clear gives no result. A new transaction is taken only
// after the previous one has finished.
// Reset (arst_n low) zeroes the filter state and sets the stiffness register to 6.
// Top level: APB register, microcode sequencer, ROM and datapath; depends on res_pkg.
`timescale 1ns / 1ps

module ramped_exponential_smoother import res_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	res_in_if.sink            feed,
	res_out_if.source         result
);

	localparam logic REG_STIFFNESS = 1'b0;

	logic [STIFF_W-1:0] stiff_q;
	logic [STEP_W-1:0]  step_q;
	uword_t             uword;
	status_t            stat;
	logic               take;
	logic               reg_sel;

	// Configuration register, written at the access phase of an APB write.
	assign reg_sel = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= STIFF_RESET;
		end else if (psel && penable && pwrite && reg_sel == REG_STIFFNESS) begin
			stiff_q <= pwdata[STIFF_W-1:0];
		end
	end

	assign prdata = (reg_sel == REG_STIFFNESS) ? {{(APB_DW-STIFF_W){1'b0}}, stiff_q} : '0;

	// Control word lookup.
	res_rom u_rom (
		.step  (step_q),
		.uword (uword)
	);

	// Jump condition of the current step.
	always_comb begin
		unique case (uword.cond)
			C_NEXT:       take = 1'b0;
			C_ALWAYS:     take = 1'b1;
			C_NO_INPUT:   take = stat.no_input;
			C_CLEAR:      take = stat.cmd_clear;
			C_STIFF_HIGH: take = stat.stiff_high;
			C_DIV_BUSY:   take = stat.div_busy;
			C_OUT_FULL:   take = stat.out_full;
			default:      take = 1'b1;
		endcase
	end

	// Step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_WAIT;
		end else if (take) begin
			step_q <= uword.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

	assign feed.ready = (uword.op == OP_LOAD);

	res_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (uword.op),
		.stiffness    (stiff_q),
		.in_valid     (feed.valid),
		.in_command   (feed.command),
		.in_sample    (feed.sample),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.out_smoothed (result.smoothed),
		.stat         (stat)
	);

	// A new transaction is never taken while the divider is still working.
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		feed.ready |-> !stat.div_busy)
		else $error("transaction accepted while divider busy");

	// A result appears only after the summing step.
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(step_q) == STEP_SUM)
		else $error("result raised outside the summing step");

	// The step counter stays inside the program.
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("step counter outside the microprogram");

endmodule
